@@ rtl/core/cbor_pkg.sv @@
// Shared types and codes for the CBOR item stream decoder.
package cbor_pkg;

  // Byte roles reported per result
  localparam logic [2:0] ROLE_INIT = 3'd0;
  localparam logic [2:0] ROLE_EXT  = 3'd1;
  localparam logic [2:0] ROLE_PAY  = 3'd2;
  localparam logic [2:0] ROLE_DONE = 3'd3;
  localparam logic [2:0] ROLE_ERR  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RESERVED = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_DEEP     = 3'd3;
  localparam logic [2:0] ST_LARGE    = 3'd4;

  // Major types that need special handling
  localparam logic [2:0] MT_BSTR  = 3'd2;
  localparam logic [2:0] MT_TSTR  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_TAG   = 3'd6;

  // Additional info boundaries
  localparam logic [4:0] AI_DIRECT_MAX = 5'd23;
  localparam logic [4:0] AI_EXT_MIN    = 5'd24;
  localparam logic [4:0] AI_EXT_MAX    = 5'd27;

  typedef enum logic [1:0] {
    AI_DIRECT = 2'd0,
    AI_EXT    = 2'd1,
    AI_RSVD   = 2'd2
  } ai_class_e;

  // Classified input byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    ai_class_e  ai_class;
    logic [3:0] ext_len;
  } cls_item_t;

  // One result
  typedef struct packed {
    logic [2:0]  role;
    logic        head_valid;
    logic [2:0]  major;
    logic [63:0] argument;
    logic [4:0]  nest_depth;
    logic        complete;
    logic [2:0]  status;
  } res_t;

endpackage

@@ rtl/core/cbor_ifs.sv @@
// Stream interfaces for the decoder's byte input and result output.
interface cbor_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface cbor_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  role;
  logic        head_valid;
  logic [2:0]  major;
  logic [63:0] argument;
  logic [4:0]  nest_depth;
  logic        complete;
  logic [2:0]  status;

  modport source (
    output valid, output role, output head_valid, output major, output argument,
    output nest_depth, output complete, output status, input ready
  );
  modport sink (
    input valid, input role, input head_valid, input major, input argument,
    input nest_depth, input complete, input status, output ready
  );
endinterface

@@ rtl/core/cbor_front.sv @@
// Front stage: accepts input bytes and classifies their additional info.
module cbor_front
  import cbor_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cbor_in_if.sink    in_i,
  output logic       valid_o,
  input  logic       ready_i,
  output cls_item_t  item_o
);

  logic      valid_q;
  cls_item_t item_q;
  cls_item_t item_d;
  logic [4:0] ai;

  assign in_i.ready = !valid_q || ready_i;
  assign ai = in_i.data_byte[4:0];

  always_comb begin
    item_d.data_byte = in_i.data_byte;
    item_d.is_last   = in_i.is_last;
    item_d.ext_len   = 4'(4'd1 << ai[1:0]);
    unique case (ai) inside
      [5'd0:AI_DIRECT_MAX]:     item_d.ai_class = AI_DIRECT;
      [AI_EXT_MIN:AI_EXT_MAX]:  item_d.ai_class = AI_EXT;
      default:                  item_d.ai_class = AI_RSVD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/core/cbor_fifo.sv @@
// Two-entry queue between the front and the back.
module cbor_fifo
  import cbor_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cls_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cls_item_t item_o
);

  cls_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign wr_en   = valid_i && ready_o;
  assign rd_en   = valid_o && ready_i;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= !wr_ptr_q;
      if (rd_en) rd_ptr_q <= !rd_ptr_q;
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

@@ rtl/core/cbor_back.sv @@
// Back stage: item walker with nesting stack and registered result.
module cbor_back
  import cbor_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cls_item_t item_i,
  cbor_out_if.source out_o
);

  localparam int unsigned PTR_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [4:0] {
    PH_INIT = 5'b00001,
    PH_EXT  = 5'b00010,
    PH_PAY  = 5'b00100,
    PH_DONE = 5'b01000,
    PH_ERR  = 5'b10000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [2:0]         err_q, err_d;
  logic [3:0]         ext_left_q, ext_left_d;
  logic [2:0]         head_major_q, head_major_d;
  logic [63:0]        arg_q, arg_d;
  logic [63:0]        pay_q, pay_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [MAX_DEPTH-1:0] one_q, one_d;   // level has exactly one item left
  logic [63:0]        stack_q [MAX_DEPTH];

  logic               out_valid_q;
  res_t               res_q, res_d;

  logic               fire;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_wa;
  logic [63:0]        stk_wd;
  logic [63:0]        stk_rd;
  logic               found;
  logic [IDX_W-1:0]   sel;
  logic               head_go, push_go, done_go;
  logic [2:0]         h_mj;
  logic [63:0]        h_arg;
  logic [63:0]        count;
  logic [7:0]         b;

  assign ready_o = !out_valid_q || out_o.ready;
  assign fire    = valid_i && ready_o;
  assign b       = item_i.data_byte;

  // Topmost open level that does not close when one item is counted off
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if ((PTR_W'(k) < ptr_q) && !one_q[k]) begin
        found = 1'b1;
        sel   = IDX_W'(k);
      end
    end
  end

  assign stk_rd = stack_q[sel];

  always_comb begin
    phase_d      = phase_q;
    err_d        = err_q;
    ext_left_d   = ext_left_q;
    head_major_d = head_major_q;
    arg_d        = arg_q;
    pay_d        = pay_q;
    ptr_d        = ptr_q;
    one_d        = one_q;
    stk_we       = 1'b0;
    stk_wa       = '0;
    stk_wd       = '0;
    head_go      = 1'b0;
    push_go      = 1'b0;
    done_go      = 1'b0;
    h_mj         = '0;
    h_arg        = '0;
    count        = '0;

    res_d            = '0;
    res_d.role       = ROLE_INIT;
    res_d.nest_depth = 5'(ptr_q);
    res_d.status     = ST_OK;

    unique case (phase_q)
      PH_ERR: begin
        res_d.role   = ROLE_ERR;
        res_d.status = err_q;
      end
      PH_DONE: begin
        res_d.role = ROLE_DONE;
      end
      PH_INIT: begin
        res_d.role = ROLE_INIT;
        unique case (item_i.ai_class)
          AI_DIRECT: begin
            head_go = 1'b1;
            h_mj    = b[7:5];
            h_arg   = 64'(b[4:0]);
          end
          AI_EXT: begin
            head_major_d = b[7:5];
            ext_left_d   = item_i.ext_len;
            arg_d        = '0;
            phase_d      = PH_EXT;
          end
          default: res_d.status = ST_RESERVED;
        endcase
      end
      PH_EXT: begin
        res_d.role = ROLE_EXT;
        arg_d      = {arg_q[55:0], b};
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_d == 4'd0) begin
          head_go = 1'b1;
          h_mj    = head_major_q;
          h_arg   = arg_d;
        end
      end
      PH_PAY: begin
        res_d.role = ROLE_PAY;
        pay_d      = pay_q - 64'd1;
        if (pay_d == 64'd0) done_go = 1'b1;
      end
      default: ;
    endcase

    if (head_go) begin
      res_d.head_valid = 1'b1;
      res_d.major      = h_mj;
      res_d.argument   = h_arg;
      case (h_mj)
        MT_BSTR, MT_TSTR: begin
          if (h_arg == 64'd0) begin
            done_go = 1'b1;
          end else begin
            pay_d   = h_arg;
            phase_d = PH_PAY;
          end
        end
        MT_ARRAY: begin
          count   = h_arg;
          push_go = 1'b1;
        end
        MT_MAP: begin
          if (h_arg[63]) begin
            res_d.status = ST_LARGE;
          end else begin
            count   = {h_arg[62:0], 1'b0};
            push_go = 1'b1;
          end
        end
        MT_TAG: begin
          count   = 64'd1;
          push_go = 1'b1;
        end
        default: done_go = 1'b1;
      endcase
    end

    if (push_go) begin
      if (count == 64'd0) begin
        done_go = 1'b1;
      end else if (ptr_q >= PTR_W'(MAX_DEPTH)) begin
        res_d.status = ST_DEEP;
      end else begin
        stk_we        = 1'b1;
        stk_wa        = ptr_q[IDX_W-1:0];
        stk_wd        = count;
        one_d[stk_wa] = (count == 64'd1);
        ptr_d         = ptr_q + PTR_W'(1);
        phase_d       = PH_INIT;
      end
    end

    // Item finished: close every level left with its last item
    if (done_go) begin
      if (found) begin
        stk_we     = 1'b1;
        stk_wa     = sel;
        stk_wd     = stk_rd - 64'd1;
        one_d[sel] = (stk_rd == 64'd2);
        ptr_d      = PTR_W'(sel) + PTR_W'(1);
        phase_d    = PH_INIT;
      end else begin
        ptr_d   = '0;
        phase_d = PH_DONE;
      end
    end

    if ((phase_q == PH_INIT) || (phase_q == PH_EXT) || (phase_q == PH_PAY)) begin
      if ((res_d.status == ST_OK) && (phase_d != PH_DONE) && item_i.is_last) begin
        res_d.status = ST_TRUNC;
      end
      if (res_d.status != ST_OK) begin
        phase_d = PH_ERR;
        err_d   = res_d.status;
      end else if (phase_d == PH_DONE) begin
        res_d.complete = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_INIT;
      err_q        <= ST_OK;
      ext_left_q   <= '0;
      head_major_q <= '0;
      arg_q        <= '0;
      pay_q        <= '0;
      ptr_q        <= '0;
      one_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        phase_q      <= phase_d;
        err_q        <= err_d;
        ext_left_q   <= ext_left_d;
        head_major_q <= head_major_d;
        arg_q        <= arg_d;
        pay_q        <= pay_d;
        ptr_q        <= ptr_d;
        one_q        <= one_d;
      end
      if (ready_o) out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
    if (fire && stk_we) stack_q[stk_wa] <= stk_wd;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.role       = res_q.role;
  assign out_o.head_valid = res_q.head_valid;
  assign out_o.major      = res_q.major;
  assign out_o.argument   = res_q.argument;
  assign out_o.nest_depth = res_q.nest_depth;
  assign out_o.complete   = res_q.complete;
  assign out_o.status     = res_q.status;

endmodule

@@ rtl/core/cbor_item_stream_decoder.sv @@
// CBOR item stream decoder: front classifier, queue, and item walker.
//
// Walks one top-level CBOR data item, taking one byte per request and
// giving one result per byte: the byte's role, the major type and 64-bit
// argument when a head completes, the nesting level, a completion flag
// on the byte that ends the top item, and a sticky status. Throughput is
// one byte per clock while the output is not stalled. A byte's result
// passes the front register, the two-entry queue and the result register
// on its way to the output. The rate is set by the walker's update, in
// which an ending item pops every finished level at once through a
// priority search over the per-level "one item left" flags plus one
// 64-bit decrement. Up to MAX_DEPTH containers may be open; the nesting
// stack has no reset or clearing pass, as each level is written on push
// before it is read. Input and output are valid/ready streams and a
// result waiting on the output does not block new bytes until the queue
// and the front register fill.
module cbor_item_stream_decoder
  import cbor_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbor_in_if.sink     in_i,
  cbor_out_if.source  out_o
);

  // front -> queue
  logic      fr_valid, fr_ready;
  cls_item_t fr_item;

  // queue -> walker
  logic      q_valid, q_ready;
  cls_item_t q_item;

  // Byte classification (additional info class, extension length)
  cbor_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .item_o  (fr_item)
  );

  // Decouples the classifier from walker stalls
  cbor_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .item_i  (fr_item),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .item_o  (q_item)
  );

  // Head assembly, payload counting, nesting stack, result register
  cbor_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .item_i  (q_item),
    .out_o   (out_o)
  );

endmodule

@@ test/cbor_item_stream_decoder_tb.sv @@
// Self-checking testbench for the CBOR item stream decoder.
`timescale 1ns / 1ps

module cbor_item_stream_decoder_tb;
  import cbor_pkg::*;

  localparam int unsigned MAX_LEVELS  = 16;
  localparam int unsigned CYCLE_LIMIT = 300_000;
  // Random items stop being appended once the stream reaches this size.
  localparam int unsigned BYTE_TARGET = 1400;
  // Past this size no new non-empty containers are opened.
  localparam int unsigned BYTE_CAP    = 1550;
  localparam int unsigned NOISE_BYTES = 24;

  // Scalar major types (the package names only the string, container and tag ones)
  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  typedef enum logic [2:0] {
    WALK_HEAD,
    WALK_EXT,
    WALK_PAYLOAD,
    WALK_DONE,
    WALK_FAILED
  } walk_phase_e;

  // How the single top-level item of this run ends
  typedef enum int {
    END_COMPLETE,
    END_RESERVED,
    END_TRUNC,
    END_DEEP,
    END_LARGE
  } end_kind_e;

  // Tracks the item walk byte by byte and keeps the results still owed by the block.
  class item_walk_tracker;
    walk_phase_e phase;
    int unsigned ext_left;
    logic [2:0]  ext_major;
    logic [63:0] arg_acc;
    logic [63:0] payload_left;
    logic [63:0] items_left[MAX_LEVELS];
    int unsigned level;
    logic [2:0]  err_code;
    res_t        owed_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned heads_seen;
    int unsigned deepest;

    function new();
      phase        = WALK_HEAD;
      ext_left     = 0;
      ext_major    = '0;
      arg_acc      = '0;
      payload_left = '0;
      level        = 0;
      err_code     = ST_OK;
      mismatches   = 0;
      results_seen = 0;
      heads_seen   = 0;
      deepest      = 0;
    endfunction

    // An item has ended: count it off the open containers, popping empty ones.
    function void close_item();
      while (level != 0) begin
        items_left[level-1] = items_left[level-1] - 64'd1;
        if (items_left[level-1] != 0) begin
          phase = WALK_HEAD;
          return;
        end
        level--;
      end
      phase = WALK_DONE;
    endfunction

    function logic [2:0] finish_head(logic [2:0] mj, logic [63:0] arg);
      logic [63:0] count;
      count = '0;
      case (mj)
        MT_BSTR, MT_TSTR: begin
          if (arg == 0) begin
            close_item();
          end else begin
            payload_left = arg;
            phase = WALK_PAYLOAD;
          end
          return ST_OK;
        end
        MT_ARRAY: count = arg;
        MT_MAP: begin
          if (arg[63]) return ST_LARGE;
          count = arg << 1;
        end
        MT_TAG: count = 64'd1;
        default: begin
          close_item();
          return ST_OK;
        end
      endcase
      if (count == 0) begin
        close_item();
        return ST_OK;
      end
      if (level >= MAX_LEVELS) return ST_DEEP;
      items_left[level] = count;
      level++;
      if (level > deepest) deepest = level;
      phase = WALK_HEAD;
      return ST_OK;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      res_t       r;
      logic [4:0] ai;
      r = '0;
      r.nest_depth = 5'(level);
      ai = b[4:0];
      case (phase)
        WALK_FAILED: begin
          r.role   = ROLE_ERR;
          r.status = err_code;
        end
        WALK_DONE: r.role = ROLE_DONE;
        default: begin
          if (phase == WALK_HEAD) begin
            r.role = ROLE_INIT;
            if (ai <= AI_DIRECT_MAX) begin
              r.head_valid = 1'b1;
              r.major      = b[7:5];
              r.argument   = 64'(ai);
              r.status     = finish_head(b[7:5], 64'(ai));
            end else if (ai <= AI_EXT_MAX) begin
              ext_major = b[7:5];
              ext_left  = 1 << (ai - AI_EXT_MIN);
              arg_acc   = '0;
              phase     = WALK_EXT;
            end else begin
              r.status = ST_RESERVED;
            end
          end else if (phase == WALK_EXT) begin
            r.role  = ROLE_EXT;
            arg_acc = {arg_acc[55:0], b};
            if (ext_left > 0) ext_left--;
            if (ext_left == 0) begin
              r.head_valid = 1'b1;
              r.major      = ext_major;
              r.argument   = arg_acc;
              r.status     = finish_head(ext_major, arg_acc);
            end
          end else begin
            r.role = ROLE_PAY;
            if (payload_left != 0) payload_left = payload_left - 64'd1;
            if (payload_left == 0) close_item();
          end
          if (r.status == ST_OK && phase != WALK_DONE && last) r.status = ST_TRUNC;
          if (r.status != ST_OK) begin
            err_code = r.status;
            phase    = WALK_FAILED;
          end else if (phase == WALK_DONE) begin
            r.complete = 1'b1;
          end
        end
      endcase
      if (r.head_valid) heads_seen++;
      owed_results.insert(owed_results.size(), r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing outstanding: %p", got);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      results_seen++;
      compare_field("role", want.role, got.role);
      compare_field("head_valid", want.head_valid, got.head_valid);
      compare_field("major", want.major, got.major);
      compare_field("argument", want.argument, got.argument);
      compare_field("nest_depth", want.nest_depth, got.nest_depth);
      compare_field("complete", want.complete, got.complete);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cbor_in_if  byte_bus ();
  cbor_out_if res_bus ();

  cbor_item_stream_decoder #(
    .MAX_DEPTH(MAX_LEVELS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_bus),
    .out_o (res_bus)
  );

  item_walk_tracker walk = new();

  // Byte stream built up front; the decoder walks exactly one top-level item.
  bit [7:0]    stream_bytes[$];
  bit          stream_last[$];
  end_kind_e   ending;
  bit          calm = 1'b0;   // no idling on either side once set
  int unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cbor_item_stream_decoder_tb NOT OK");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_bus.valid && byte_bus.ready)
        walk.note_byte(byte_bus.data_byte, byte_bus.is_last);
      if (res_bus.valid && res_bus.ready)
        walk.check_result({res_bus.role, res_bus.head_valid, res_bus.major, res_bus.argument,
                           res_bus.nest_depth, res_bus.complete, res_bus.status});
    end
  end

  // ---------------------------------------------------------------------------
  // Stream construction
  // ---------------------------------------------------------------------------

  function automatic void put(bit [7:0] b, bit last = 1'b0);
    stream_bytes.insert(stream_bytes.size(), b);
    stream_last.insert(stream_last.size(), last);
  endfunction

  // Emits a head in its shortest form, or now and then a wider one (legal in CBOR,
  // and it drives zero-filled extension bytes).
  function automatic void put_head(logic [2:0] mj, logic [63:0] arg);
    int unsigned n;
    logic [4:0]  ai;
    if (arg < 64'd24)                n = 0;
    else if (arg < 64'h100)          n = 1;
    else if (arg < 64'h1_0000)       n = 2;
    else if (arg < 64'h1_0000_0000)  n = 4;
    else                             n = 8;
    if ($urandom_range(0, 3) == 0)
      while (n < 8 && $urandom_range(0, 1) == 1) n = (n == 0) ? 1 : n * 2;
    case (n)
      0:       ai = arg[4:0];
      1:       ai = AI_EXT_MIN;
      2:       ai = AI_EXT_MIN + 5'd1;
      4:       ai = AI_EXT_MIN + 5'd2;
      default: ai = AI_EXT_MAX;
    endcase
    put({mj, ai});
    for (int i = int'(n) - 1; i >= 0; i--) put(arg[8*i +: 8]);
  endfunction

  // Argument spread over every encoding width, extremes included.
  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 5))
      0:       return 64'($urandom_range(0, 23));
      1:       return 64'($urandom_range(0, 255));
      2:       return 64'($urandom_range(0, 65535));
      3:       return 64'($urandom);
      4:       return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return 64'd23;
          2:       return 64'd24;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Opens single-item arrays or tags until `target` containers are open.
  function automatic int unsigned open_chain(int unsigned depth, int unsigned target);
    while (depth < target) begin
      if ($urandom_range(0, 1) == 1) put_head(MT_ARRAY, 64'd1);
      else                           put_head(MT_TAG, rand_arg());
      depth++;
    end
    return depth;
  endfunction

  // One well-formed item with random content; `depth` is the number of containers
  // around it. Nothing here can raise an error on its own.
  function automatic void put_item(int unsigned depth);
    int unsigned pick;
    int unsigned n;
    int unsigned len;
    bit          nest_ok;
    logic [2:0]  mj;
    nest_ok = depth < MAX_LEVELS && stream_bytes.size() < BYTE_CAP;
    pick = $urandom_range(0, 99);
    // At full stack depth, or once the stream reaches BYTE_CAP, only empty containers are put.
    if (pick >= 65 && !nest_ok) begin
      put_head(($urandom_range(0, 1) == 1) ? MT_ARRAY : MT_MAP, 64'd0);
      return;
    end
    if (pick < 45) begin
      n  = $urandom_range(0, 2);
      mj = (n == 0) ? MT_UINT : (n == 1) ? MT_NINT : MT_SIMPLE;
      put_head(mj, rand_arg());
    end else if (pick < 65) begin
      len = $urandom_range(0, 9);
      put_head(($urandom_range(0, 1) == 1) ? MT_BSTR : MT_TSTR, 64'(len));
      repeat (len) put(8'($urandom_range(0, 255)));
    end else if (pick < 77) begin
      n = $urandom_range(0, 3);
      put_head(MT_ARRAY, 64'(n));
      repeat (n) put_item(depth + 1);
    end else if (pick < 87) begin
      n = $urandom_range(0, 2);
      put_head(MT_MAP, 64'(n));
      repeat (2 * n) put_item(depth + 1);
    end else if (pick < 97) begin
      put_head(MT_TAG, rand_arg());
      put_item(depth + 1);
    end else begin
      // Dive to the full stack depth, then let the inner items pop every level at once.
      void'(open_chain(depth, MAX_LEVELS - 1));
      put_head(MT_ARRAY, 64'd3);
      repeat (3) put_item(MAX_LEVELS);
    end
  endfunction

  function automatic void build_stream();
    int unsigned top_items;
    int unsigned first;
    logic [63:0] top_count;

    // Directed opening, all inside the top-level array at depth 1.
    put(8'h00);                              // smallest unsigned
    put(8'hF7);                              // simple value, largest direct info
    put(8'h19); put(8'hAB); put(8'hCD);      // two-byte unsigned
    put(8'h40);                              // empty byte string
    put(8'h62); put(8'h61); put(8'h62);      // two-byte text string
    put(8'h80);                              // empty array
    put(8'hA0);                              // empty map
    put(8'hC1); put(8'h01);                  // tag around a small unsigned
    put(8'hA1); put(8'h01); put(8'h37);      // one-entry map, negative value
    top_items = 9;

    while (stream_bytes.size() < BYTE_TARGET) begin
      put_item(1);
      top_items++;
    end

    case (ending)
      END_COMPLETE: begin
        // is_last on the closing byte must not count as truncation
        stream_last[stream_last.size() - 1] = $urandom_range(0, 1);
      end
      END_RESERVED: put({3'($urandom_range(0, 7)), 5'($urandom_range(28, 31))},
                        $urandom_range(0, 1));
      END_TRUNC: begin
        first = stream_bytes.size();
        put_item(1);
        stream_last[$urandom_range(first, stream_bytes.size() - 1)] = 1'b1;
      end
      END_DEEP: begin
        void'(open_chain(1, MAX_LEVELS));
        case ($urandom_range(0, 2))
          0:       put_head(MT_ARRAY, 64'($urandom_range(1, 5)));
          1:       put_head(MT_MAP, 64'($urandom_range(1, 5)));
          default: put_head(MT_TAG, rand_arg());
        endcase
      end
      default: begin
        // Map count with the top bit set: twice the count overflows
        put({MT_MAP, AI_EXT_MAX});
        put(8'h80 | 8'($urandom_range(0, 127)));
        repeat (7) put(8'($urandom_range(0, 255)));
      end
    endcase

    // Trailing bytes land after completion or after the sticky error.
    repeat (NOISE_BYTES) put(8'($urandom_range(0, 255)), $urandom_range(0, 1));

    // Top-level array head, prepended: an exact count when the item should finish,
    // otherwise the largest count so that it never does.
    top_count = (ending == END_COMPLETE) ? 64'(top_items) : '1;
    for (int i = 0; i < 8; i++) begin
      stream_bytes.push_front(top_count[8*i +: 8]);
      stream_last.push_front(1'b0);
    end
    stream_bytes.push_front({MT_ARRAY, AI_EXT_MAX});
    stream_last.push_front(1'b0);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  task automatic send_stream();
    int unsigned idle_odds;
    idle_odds = 0;
    for (int unsigned i = 0; i < stream_bytes.size(); i++) begin
      // Idle rate changes every 64 requests; a zero rate gives clean stretches.
      if (i % 64 == 0) idle_odds = $urandom_range(0, 3);
      if (i * 100 > stream_bytes.size() * 85) calm = 1'b1;
      if (!calm && idle_odds != 0 && $urandom_range(1, 4 * idle_odds) == 1) begin
        byte_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      byte_bus.valid     <= 1'b1;
      byte_bus.data_byte <= stream_bytes[i];
      byte_bus.is_last   <= stream_last[i];
      @(posedge clk_i);
      while (!byte_bus.ready) @(posedge clk_i);
      @(negedge clk_i);
    end
    byte_bus.valid <= 1'b0;
  endtask

  // Result side back-pressure in random bursts.
  initial begin
    int unsigned hold;
    int unsigned stall_odds;
    int unsigned tick;
    hold = 0;
    stall_odds = 0;
    tick = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (tick % 80 == 0) stall_odds = $urandom_range(0, 3);
      tick++;
      if (!calm && hold == 0 && stall_odds != 0 && $urandom_range(1, 4 * stall_odds) == 1)
        hold = $urandom_range(1, 11);
      if (calm) hold = 0;
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        hold--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = '0;
    byte_bus.is_last   = 1'b0;

    ending = end_kind_e'($urandom_range(0, 4));
    build_stream();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_stream();

    // Drain: wait until every owed result has been checked.
    while (walk.owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("walked %0d bytes, %0d results checked, %0d heads, deepest nesting %0d",
             stream_bytes.size(), walk.results_seen, walk.heads_seen, walk.deepest);
    $display("top-level item ended by %s", ending.name());
    if (walk.mismatches == 0 && walk.owed_results.size() == 0) begin
      $display("cbor_item_stream_decoder_tb OK");
    end else begin
      $display("cbor_item_stream_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ cbor_item_stream_decoder.f @@
rtl/core/cbor_pkg.sv
rtl/core/cbor_ifs.sv
rtl/core/cbor_front.sv
rtl/core/cbor_fifo.sv
rtl/core/cbor_back.sv
rtl/core/cbor_item_stream_decoder.sv
test/cbor_item_stream_decoder_tb.sv
